// ----- sv/ctcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ctcm_pkg;

    localparam int unsigned SCALE_W   = 32;
    localparam int unsigned PERIOD_W  = 32;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned CAP_W     = 16;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned IN_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 88;
    localparam int unsigned DIV_CNT_W = $clog2(SCALE_W);

    localparam logic [SCALE_W-1:0] SCALE_RESET   = 32'd228800000;
    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd4883;
    localparam logic [COUNT_W-1:0] DISCH_RESET   = 16'd160;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCH   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_UPDATE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OVERFLOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CAPTURE  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_CHARGING    = 2'd1,
        PH_DISCHARGING = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        VAL_KEEP  = 2'd0,
        VAL_TAKE  = 2'd1,
        VAL_CLAMP = 2'd2
    } val_kind_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_DIV   = 2'd1,
        S_WRITE = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic div_step;
        logic write;
    } ctcm_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } ctcm_status_t;

endpackage

`default_nettype wire

// ----- sv/ctcm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctcm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire ctcm_pkg::ctcm_status_t status,
    output ctcm_pkg::ctcm_cmd_t        cmd
);

    ctcm_pkg::ctrl_state_t state_reg;
    ctcm_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctcm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctcm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_div ? ctcm_pkg::S_DIV : ctcm_pkg::S_WRITE;
                end
            end
            ctcm_pkg::S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ctcm_pkg::S_WRITE;
                end
            end
            ctcm_pkg::S_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = ctcm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ctcm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ctcm_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = in_valid;
            end
            ctcm_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ctcm_pkg::S_WRITE:
            begin
                cmd.write = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/ctcm_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctcm_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ctcm_pkg::ctcm_cmd_t               cmd,
    output ctcm_pkg::ctcm_status_t                 status,
    input  wire logic [ctcm_pkg::MODE_W-1:0]       in_mode,
    input  wire logic [ctcm_pkg::CAP_W-1:0]        in_cap,
    input  wire logic                              cfg_we,
    input  wire logic [ctcm_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  wire logic [ctcm_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ctcm_pkg::OUT_DATA_W-1:0]        out_data
);

    localparam int unsigned SW = ctcm_pkg::SCALE_W;
    localparam int unsigned CW = ctcm_pkg::COUNT_W;
    localparam int unsigned PW = ctcm_pkg::PERIOD_W;

    // configuration
    logic [SW-1:0] scale_reg;
    logic [CW-1:0] timeout_reg;
    logic [CW-1:0] disch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= ctcm_pkg::SCALE_RESET;
            timeout_reg <= ctcm_pkg::TIMEOUT_RESET;
            disch_reg   <= ctcm_pkg::DISCH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                ctcm_pkg::CFG_SCALE:   scale_reg   <= cfg_wdata;
                ctcm_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata[CW-1:0];
                ctcm_pkg::CFG_DISCH:   disch_reg   <= cfg_wdata[CW-1:0];
                default:               ;
            endcase
        end
    end

    // meter state
    ctcm_pkg::phase_t phase_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    period_reg;
    logic [SW-1:0]    value_reg;

    // per-item results held until the result is written out
    ctcm_pkg::val_kind_t kind_reg;
    logic [CW-1:0]       preload_reg;
    logic                load_tmr_reg;
    logic                tout_reg;

    // event decode
    ctcm_pkg::phase_t    phase_next;
    logic [CW-1:0]       count_next;
    logic [PW-1:0]       period_next;
    logic [PW-1:0]       divisor;
    ctcm_pkg::val_kind_t kind_next;
    logic [CW-1:0]       preload_next;
    logic                load_tmr_next;
    logic                tout_next;
    logic                to_disch;
    logic [CW:0]         count_inc;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        period_next   = period_reg;
        divisor       = period_reg;
        kind_next     = ctcm_pkg::VAL_KEEP;
        preload_next  = '0;
        load_tmr_next = 1'b0;
        tout_next     = 1'b0;
        to_disch      = 1'b0;
        count_inc     = {1'b0, count_reg} + {{CW{1'b0}}, 1'b1};
        unique case (in_mode)
            ctcm_pkg::MODE_UPDATE:
            begin
                if (phase_reg == ctcm_pkg::PH_IDLE)
                begin
                    phase_next    = ctcm_pkg::PH_CHARGING;
                    count_next    = '0;
                    load_tmr_next = 1'b1;
                end
            end
            ctcm_pkg::MODE_OVERFLOW:
            begin
                if (phase_reg == ctcm_pkg::PH_DISCHARGING)
                begin
                    phase_next = ctcm_pkg::PH_IDLE;
                end
                else if (phase_reg == ctcm_pkg::PH_CHARGING)
                begin
                    count_next = count_inc[CW-1:0];
                    if (count_inc >= {1'b0, timeout_reg})
                    begin
                        period_next = {count_inc[CW-1:0], {(PW-CW){1'b0}}};
                        divisor     = period_next;
                        kind_next   = ctcm_pkg::VAL_TAKE;
                        tout_next   = 1'b1;
                        to_disch    = 1'b1;
                    end
                    else
                    begin
                        // early upper bound from the overflow count alone
                        divisor   = {count_inc[CW-1:0], {(PW-CW){1'b0}}};
                        kind_next = ctcm_pkg::VAL_CLAMP;
                    end
                end
            end
            ctcm_pkg::MODE_CAPTURE:
            begin
                if (phase_reg == ctcm_pkg::PH_CHARGING)
                begin
                    period_next = {count_reg, in_cap};
                    divisor     = period_next;
                    kind_next   = ctcm_pkg::VAL_TAKE;
                    to_disch    = 1'b1;
                end
            end
            default:
            begin
                kind_next = ctcm_pkg::VAL_KEEP;
            end
        endcase
        if (to_disch)
        begin
            phase_next    = ctcm_pkg::PH_DISCHARGING;
            preload_next  = '0 - disch_reg;
            load_tmr_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ctcm_pkg::PH_DISCHARGING;
            count_reg  <= '0;
            period_reg <= '0;
        end
        else if (cmd.load)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            period_reg <= period_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind_next;
            preload_reg  <= preload_next;
            load_tmr_reg <= load_tmr_next;
            tout_reg     <= tout_next;
        end
    end

    // restoring divider, one quotient bit per cycle; a zero divisor gives all ones
    logic [SW-1:0]                  rem_reg;
    logic [SW-1:0]                  quo_reg;
    logic [PW-1:0]                  dvs_reg;
    logic [ctcm_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [SW:0]                    trial;
    logic                           fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SW-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= '0;
            quo_reg <= scale_reg;
            dvs_reg <= divisor;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? SW'(trial - {1'b0, dvs_reg}) : trial[SW-1:0];
            quo_reg <= {quo_reg[SW-2:0], fits};
        end
    end

    // value update and output register
    logic [SW-1:0]             value_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [ctcm_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [ctcm_pkg::OUT_DATA_W-1:0] out_data_next;
    logic                      charging;

    always_comb
    begin
        unique case (kind_reg)
            ctcm_pkg::VAL_TAKE:  value_next = quo_reg;
            ctcm_pkg::VAL_CLAMP: value_next = (value_reg > quo_reg) ? quo_reg : value_reg;
            default:             value_next = value_reg;
        endcase
        charging      = phase_reg == ctcm_pkg::PH_CHARGING;
        out_data_next = {1'b0, tout_reg, charging, phase_reg != ctcm_pkg::PH_IDLE,
                         load_tmr_reg, preload_reg, charging, phase_reg,
                         period_reg, value_next};
        out_valid_next = out_valid_reg;
        if (cmd.write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.write)
            begin
                value_reg <= value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        status.need_div = kind_next != ctcm_pkg::VAL_KEEP;
        status.div_last = div_cnt_reg == ctcm_pkg::DIV_CNT_W'(SW - 1);
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_write_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!out_valid_reg || out_ready))
        else $error("result written over an untaken item");
    a_write_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> out_valid_reg)
        else $error("written result not presented");
    a_load_restarts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (div_cnt_reg == '0))
        else $error("divider not restarted on a new item");
    a_no_load_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !cmd.load && !cmd.write)
        else $error("item taken or written during division");
`endif

endmodule

`default_nettype wire

// ----- sv/charge_time_current_meter_top.sv -----
// charge-time current meter sequencer
// input channel s_*: one item per event; tuser carries the event kind (update,
// timer overflow, comparator capture), tdata the captured low timer bits.
// output channel m_*: one result item per input item with the measured value,
// last period, phase and the electrode and timer controls for that phase.
// config channel cfg_*: always ready; index 0 scale, 1 timeout overflows,
// 2 discharge ticks; other indexes are dropped. write only while idle.
// an item that ends a charge period or raises the overflow count while
// charging runs a restoring divider, one quotient bit per cycle, before its
// result goes to the output register; other events go there directly. a
// new item is taken only once the last result has been written there.
// the output register holds a result while m_tready is low; the block works
// on the next item meanwhile and waits only when it has a second result ready.
// reset loads the default configuration, enters the discharging phase and
// clears the overflow count, the value and the period.
`timescale 1ns / 1ps
`default_nettype none

module charge_time_current_meter_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // capture_count
    input  wire logic [ctcm_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode
    input  wire logic [ctcm_pkg::MODE_W-1:0]        s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // current_value, last_period, phase, drive_charge, timer_preload,
    // load_timer, timer_run, capture_enable, timed_out, zero pad
    output logic [ctcm_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ctcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ctcm_pkg::CFG_DAT_W-1:0]     cfg_data
);

    ctcm_pkg::ctcm_cmd_t    cmd;
    ctcm_pkg::ctcm_status_t status;

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    ctcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    ctcm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_cap    (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/ctcm_result_check.sv -----
`timescale 1ns / 1ps

module ctcm_result_check
    import ctcm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    input  wire logic [IN_DATA_W-1:0]     s_tdata,
    input  wire logic [MODE_W-1:0]        s_tuser,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [OUT_DATA_W-1:0]    m_tdata,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DAT_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            pending,
    output int                            checked
);

    // m_tdata layout, top bit first
    typedef struct packed {
        logic                pad;
        logic                timed_out;
        logic                capture_enable;
        logic                timer_run;
        logic                load_timer;
        logic [COUNT_W-1:0]  timer_preload;
        logic                drive_charge;
        phase_t              phase;
        logic [PERIOD_W-1:0] last_period;
        logic [SCALE_W-1:0]  current_value;
    } meter_result_t;

    logic [SCALE_W-1:0]  scale;
    logic [COUNT_W-1:0]  timeout_cnt;
    logic [COUNT_W-1:0]  disch_ticks;
    phase_t              ph;
    logic [COUNT_W-1:0]  ovf_cnt;
    logic [SCALE_W-1:0]  value;
    logic [PERIOD_W-1:0] period;

    meter_result_t expected_results[$];

    task automatic note_mismatch(input string msg);
        if (mismatches < 50)
            $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic logic [SCALE_W-1:0] ratio(input logic [PERIOD_W-1:0] p);
        if (p == '0)
            return '1;
        return scale / p;
    endfunction

    task automatic latch_period(input logic [CAP_W-1:0] low);
        period = {ovf_cnt, low};
        value  = ratio(period);
    endtask

    task automatic apply_event(input logic [MODE_W-1:0] kind, input logic [CAP_W-1:0] cap,
                               output meter_result_t r);
        logic [COUNT_W:0]   next_cnt;
        logic [SCALE_W-1:0] bound;
        logic               to_disch;
        r = '0;
        to_disch = 1'b0;
        case (kind)
            MODE_UPDATE: begin
                if (ph == PH_IDLE)
                begin
                    ph = PH_CHARGING;
                    ovf_cnt = '0;
                    r.load_timer = 1'b1;
                end
            end
            MODE_OVERFLOW: begin
                if (ph == PH_DISCHARGING)
                    ph = PH_IDLE;
                else if (ph == PH_CHARGING)
                begin
                    next_cnt = {1'b0, ovf_cnt} + 1'b1;
                    ovf_cnt = next_cnt[COUNT_W-1:0];
                    if (next_cnt >= {1'b0, timeout_cnt})
                    begin
                        latch_period('0);
                        r.timed_out = 1'b1;
                        to_disch = 1'b1;
                    end
                    else
                    begin
                        // early upper bound from the overflows alone
                        bound = ratio({ovf_cnt, 16'd0});
                        if (value > bound)
                            value = bound;
                    end
                end
            end
            MODE_CAPTURE: begin
                if (ph == PH_CHARGING)
                begin
                    latch_period(cap);
                    to_disch = 1'b1;
                end
            end
            default: ;
        endcase
        if (to_disch)
        begin
            ph = PH_DISCHARGING;
            r.timer_preload = 16'd0 - disch_ticks;
            r.load_timer = 1'b1;
        end
        r.current_value  = value;
        r.last_period    = period;
        r.phase          = ph;
        r.drive_charge   = (ph == PH_CHARGING);
        r.timer_run      = (ph != PH_IDLE);
        r.capture_enable = (ph == PH_CHARGING);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        meter_result_t got;
        meter_result_t want;
        if (!rst_n)
        begin
            scale       = SCALE_RESET;
            timeout_cnt = TIMEOUT_RESET;
            disch_ticks = DISCH_RESET;
            ph          = PH_DISCHARGING;
            ovf_cnt     = '0;
            value       = '0;
            period      = '0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = meter_result_t'(m_tdata);
                if (expected_results.size() == 0)
                    note_mismatch("result item with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("current_value", got.current_value, want.current_value);
                    check_field("last_period", got.last_period, want.last_period);
                    check_field("phase", got.phase, want.phase);
                    check_field("drive_charge", got.drive_charge, want.drive_charge);
                    check_field("timer_preload", got.timer_preload, want.timer_preload);
                    check_field("load_timer", got.load_timer, want.load_timer);
                    check_field("timer_run", got.timer_run, want.timer_run);
                    check_field("capture_enable", got.capture_enable, want.capture_enable);
                    check_field("timed_out", got.timed_out, want.timed_out);
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCALE:   scale = cfg_data;
                    CFG_TIMEOUT: timeout_cnt = cfg_data[COUNT_W-1:0];
                    CFG_DISCH:   disch_ticks = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                apply_event(s_tuser, s_tdata, want);
                expected_results.push_back(want);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- tb/charge_time_current_meter_top_tb.sv -----
`timescale 1ns / 1ps

module charge_time_current_meter_top_tb;
    import ctcm_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_RESERVED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED        = 2'd3;
    localparam int                   ITEMS_PER_SETTING = 210;
    localparam int                   DRAIN_CYCLES      = 40;
    localparam int                   IDLE_LIMIT        = 2000;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic [MODE_W-1:0]       s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;

    int mismatches;
    int pending;
    int checked;
    int items_sent;
    int burst_left;
    int settings_run;

    charge_time_current_meter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ctcm_result_check u_result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: segments of always ready, random ready, and long stalls
    initial
    begin : rx_pattern
        int seg;
        int style;
        int run;
        m_tready = 1'b0;
        forever
        begin
            style = $urandom_range(0, 2);
            seg = $urandom_range(20, 200);
            while (seg > 0)
            begin
                case (style)
                    0: begin
                        @(negedge clk);
                        m_tready <= 1'b1;
                        seg--;
                    end
                    1: begin
                        @(negedge clk);
                        m_tready <= ($urandom_range(0, 3) != 0);
                        seg--;
                    end
                    default: begin
                        run = $urandom_range(1, 25);
                        @(negedge clk);
                        m_tready <= 1'b0;
                        repeat (run) @(negedge clk);
                        m_tready <= 1'b1;
                        seg -= run + 1;
                    end
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic logic [CAP_W-1:0] rand_cap();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_event(input logic [MODE_W-1:0] kind, input logic [CAP_W-1:0] cap);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata  <= 16'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= cap;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // let every result come out, then give the divider time to settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // discharge ends, charge starts, some overflows, usually a capture
    task automatic charge_cycle(input int max_ovf);
        send_event(MODE_OVERFLOW, rand_cap());
        send_event(MODE_UPDATE, rand_cap());
        repeat ($urandom_range(0, max_ovf)) send_event(MODE_OVERFLOW, rand_cap());
        if ($urandom_range(0, 7) != 0)
            send_event(MODE_CAPTURE, rand_cap());
    endtask

    task automatic run_setting(input logic [SCALE_W-1:0] scale, input logic [COUNT_W-1:0] tmo,
                               input logic [COUNT_W-1:0] ticks, input int max_ovf);
        int stop_at;
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_TIMEOUT, {16'($urandom), tmo});
        write_reg(CFG_DISCH, {16'($urandom), ticks});
        write_reg(CFG_UNUSED, $urandom);
        settings_run++;
        stop_at = items_sent + ITEMS_PER_SETTING;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_event(2'($urandom), rand_cap());
            charge_cycle(max_ovf);
        end
        drain();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = MODE_UPDATE;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_SCALE;
        cfg_data   = '0;
        items_sent = 0;
        burst_left = 0;
        settings_run = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ignored events in every phase, zero period, clamp, timeout
        write_reg(CFG_SCALE, 32'h0010_0000);
        write_reg(CFG_TIMEOUT, 32'd3);
        write_reg(CFG_DISCH, 32'd1);
        settings_run++;
        send_event(MODE_RESERVED, 16'hFFFF);
        send_event(MODE_UPDATE, 16'h0000);
        send_event(MODE_CAPTURE, 16'h1234);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_OVERFLOW, 16'hFFFF);
        send_event(MODE_CAPTURE, 16'hFFFF);
        send_event(MODE_RESERVED, 16'h0000);
        send_event(MODE_UPDATE, 16'h5555);
        send_event(MODE_UPDATE, 16'hAAAA);
        send_event(MODE_RESERVED, 16'h00FF);
        send_event(MODE_CAPTURE, 16'h0000);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_UPDATE, 16'h0000);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_UPDATE, 16'h0000);
        send_event(MODE_CAPTURE, 16'hFFFF);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_UPDATE, 16'h0000);
        send_event(MODE_OVERFLOW, 16'h0000);
        send_event(MODE_CAPTURE, 16'h8000);
        drain();

        run_setting(SCALE_RESET, TIMEOUT_RESET, DISCH_RESET, 3);
        run_setting(32'hFFFF_FFFF, 16'd1, 16'hFFFF, 2);
        run_setting(32'd0, 16'd2, 16'd0, 4);
        run_setting(32'd1, 16'hFFFF, 16'd1, 8);
        run_setting($urandom, 16'($urandom_range(3, 12)), 16'($urandom), 12);
        run_setting($urandom, 16'd0, 16'($urandom), 3);
        run_setting($urandom, 16'($urandom_range(1, 6)), 16'($urandom), 6);
        run_setting($urandom, 16'($urandom), 16'($urandom), 4);

        drain();
        $display("summary: %0d events sent under %0d register settings", items_sent,
                 settings_run);
        $display("summary: %0d results compared, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
